// ===== rtl/salls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salls_pkg
// Shared constants, types and microcode encodings for the sorted linked list.
// ----------------------------------------------------------------------------
package salls_pkg;

   // store geometry
   localparam int SLOTS     = 64;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int LINK_W    = SLOT_W + 1;
   localparam int MEM_DEPTH = 1 << SLOT_W;
   localparam int STEP_W    = $clog2(SLOTS + 1);

   // field widths
   localparam int CMD_W      = 2;
   localparam int KEY_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 6;
   localparam int COUNT_W    = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef logic [LINK_W-1:0] link_type;
   typedef logic [SLOT_W-1:0] addr_type;

   // invalid link, end of a chain
   localparam link_type NIL = LINK_W'(SLOTS);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_DUP       = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // datapath actions, one per control word
   typedef enum logic [3:0] {
      ACT_NONE      = 4'd0,
      ACT_ACCEPT    = 4'd1,
      ACT_WALK_INIT = 4'd2,
      ACT_WALK      = 4'd3,
      ACT_INS_RD    = 4'd4,
      ACT_INS_A     = 4'd5,
      ACT_INS_B     = 4'd6,
      ACT_DEL_A     = 4'd7,
      ACT_DEL_B     = 4'd8,
      ACT_FOUND     = 4'd9,
      ACT_SET_DUP   = 4'd10,
      ACT_SET_NF    = 4'd11,
      ACT_SET_FULL  = 4'd12,
      ACT_CLEAR     = 4'd13,
      ACT_EMIT      = 4'd14
   } act_type;

   // sequencer jump conditions
   typedef enum logic [2:0] {
      JMP_NEXT     = 3'd0,
      JMP_GOTO     = 3'd1,
      JMP_DISPATCH = 3'd2,
      JMP_WALK     = 3'd3,
      JMP_WAIT_RSP = 3'd4
   } jmp_type;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   // microprogram labels
   localparam upc_type U_IDLE  = UPC_W'(0);
   localparam upc_type U_WINIT = UPC_W'(1);
   localparam upc_type U_WALK  = UPC_W'(2);
   localparam upc_type U_INSRD = UPC_W'(3);
   localparam upc_type U_INSA  = UPC_W'(4);
   localparam upc_type U_INSB  = UPC_W'(5);
   localparam upc_type U_DELA  = UPC_W'(6);
   localparam upc_type U_DELB  = UPC_W'(7);
   localparam upc_type U_SRCH  = UPC_W'(8);
   localparam upc_type U_DUP   = UPC_W'(9);
   localparam upc_type U_NF    = UPC_W'(10);
   localparam upc_type U_FULL  = UPC_W'(11);
   localparam upc_type U_CLR   = UPC_W'(12);
   localparam upc_type U_EMIT  = UPC_W'(13);

   typedef struct packed {
      act_type act;
      jmp_type jmp;
      upc_type target;
   } ucode_type;

   // condition inputs to the sequencer
   typedef struct packed {
      logic    req_fire;
      cmd_type cmd;
      logic    full;
      logic    walk_more;
      logic    found;
      logic    rsp_free;
   } seq_flags_type;

   // link value of a slot after reset or clear: next slot, last one ends the chain
   function automatic link_type reset_link(input addr_type a);
      link_type r;
      if (LINK_W'(a) < LINK_W'(SLOTS - 1)) begin
         r = LINK_W'(a) + LINK_W'(1);
      end else begin
         r = NIL;
      end
      return r;
   endfunction

endpackage

// ===== rtl/salls_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salls_store
// Key and link memories with one shared registered read port. Link entries
// carry valid bits; an entry not written since reset or clear reads as its
// rebuilt free-chain link.
// ----------------------------------------------------------------------------
module salls_store (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  salls_pkg::addr_type    rd_addr,
   input  logic                   key_we,
   input  salls_pkg::addr_type    key_waddr,
   input  logic [31:0]            key_wdata,
   input  logic                   link_we,
   input  salls_pkg::addr_type    link_waddr,
   input  salls_pkg::link_type    link_wdata,
   output logic signed [31:0]     key_rd,
   output salls_pkg::link_type    link_rd
);
   import salls_pkg::*;

   logic [KEY_W-1:0]  key_mem [MEM_DEPTH];
   link_type          link_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff, valid_in;

   logic [KEY_W-1:0] key_rd_ff;
   link_type         link_rd_ff;
   logic             rd_valid_ff;
   addr_type         rd_addr_ff;

   // key memory
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   // link memory
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff  <= link_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   // valid bits, cleared at once by reset or clear
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (link_we) begin
         valid_in[link_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign key_rd  = $signed(key_rd_ff);
   assign link_rd = rd_valid_ff ? link_rd_ff : reset_link(rd_addr_ff);

endmodule

// ===== rtl/salls_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salls_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module salls_useq (
   input  logic                     clock,
   input  logic                     reset,
   input  salls_pkg::seq_flags_type flags,
   output salls_pkg::ucode_type     ctl
);
   import salls_pkg::*;

   upc_type upc_ff, upc_in;

   // control store
   function automatic ucode_type rom(input upc_type a);
      ucode_type w;
      case (a)
         U_IDLE:  w = '{act: ACT_ACCEPT,    jmp: JMP_DISPATCH, target: U_IDLE};
         U_WINIT: w = '{act: ACT_WALK_INIT, jmp: JMP_NEXT,     target: U_IDLE};
         U_WALK:  w = '{act: ACT_WALK,      jmp: JMP_WALK,     target: U_IDLE};
         U_INSRD: w = '{act: ACT_INS_RD,    jmp: JMP_NEXT,     target: U_IDLE};
         U_INSA:  w = '{act: ACT_INS_A,     jmp: JMP_NEXT,     target: U_IDLE};
         U_INSB:  w = '{act: ACT_INS_B,     jmp: JMP_GOTO,     target: U_EMIT};
         U_DELA:  w = '{act: ACT_DEL_A,     jmp: JMP_NEXT,     target: U_IDLE};
         U_DELB:  w = '{act: ACT_DEL_B,     jmp: JMP_GOTO,     target: U_EMIT};
         U_SRCH:  w = '{act: ACT_FOUND,     jmp: JMP_GOTO,     target: U_EMIT};
         U_DUP:   w = '{act: ACT_SET_DUP,   jmp: JMP_GOTO,     target: U_EMIT};
         U_NF:    w = '{act: ACT_SET_NF,    jmp: JMP_GOTO,     target: U_EMIT};
         U_FULL:  w = '{act: ACT_SET_FULL,  jmp: JMP_GOTO,     target: U_EMIT};
         U_CLR:   w = '{act: ACT_CLEAR,     jmp: JMP_GOTO,     target: U_EMIT};
         U_EMIT:  w = '{act: ACT_EMIT,      jmp: JMP_WAIT_RSP, target: U_IDLE};
         default: w = '{act: ACT_NONE,      jmp: JMP_GOTO,     target: U_IDLE};
      endcase
      return w;
   endfunction

   assign ctl = rom(upc_ff);

   // next step
   always_comb begin
      upc_in = upc_ff;
      case (ctl.jmp)
         JMP_NEXT: begin
            upc_in = upc_ff + UPC_W'(1);
         end
         JMP_GOTO: begin
            upc_in = ctl.target;
         end
         JMP_DISPATCH: begin
            if (flags.req_fire) begin
               if (flags.cmd == CMD_CLEAR) begin
                  upc_in = U_CLR;
               end else if (flags.cmd == CMD_INSERT && flags.full) begin
                  upc_in = U_FULL;
               end else begin
                  upc_in = U_WINIT;
               end
            end
         end
         JMP_WALK: begin
            if (!flags.walk_more) begin
               if (flags.cmd == CMD_INSERT) begin
                  upc_in = flags.found ? U_DUP : U_INSRD;
               end else if (!flags.found) begin
                  upc_in = U_NF;
               end else if (flags.cmd == CMD_DELETE) begin
                  upc_in = U_DELA;
               end else begin
                  upc_in = U_SRCH;
               end
            end
         end
         JMP_WAIT_RSP: begin
            if (flags.rsp_free) begin
               upc_in = ctl.target;
            end
         end
         default: begin
            upc_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== rtl/sorted_array_linked_list.sv =====
`timescale 1ns / 1ps
// Sequence: clear and an insert into a full store go straight to the response;
// other commands walk the list, up to 64 elements, then do any update and respond.
// Throughput: one command at a time; the list walk reads one element per cycle
// from the shared key/link memory read port and sets the rate.
// Reset (synchronous, active high) empties the list and rebuilds the free chain.
// ----------------------------------------------------------------------------
// sorted_array_linked_list
// Sorted singly linked list of signed keys in a fixed slot store, with a free
// list, run by a microcoded sequencer over a simple datapath.
// ----------------------------------------------------------------------------
module sorted_array_linked_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[1:0], key[33:2], zero[39:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], slot[7:2], element_count[14:8], zero[15]
);
   import salls_pkg::*;

   ucode_type     ctl;
   seq_flags_type flags;

   // datapath registers
   cmd_type               cmd_ff, cmd_in;
   logic signed [31:0]    key_ff, key_in;
   link_type              prev_ff, prev_in;
   link_type              cur_ff, cur_in;
   link_type              curlink_ff, curlink_in;
   logic [STEP_W-1:0]     steps_ff, steps_in;
   link_type              list_head_ff, list_head_in;
   link_type              free_head_ff, free_head_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   status_type            res_status_ff, res_status_in;
   addr_type              res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // store ports
   addr_type           rd_addr;
   logic               key_we;
   logic               link_we;
   addr_type           link_waddr;
   link_type           link_wdata;
   logic signed [31:0] key_rd;
   link_type           link_rd;
   logic               clear;

   logic req_fire;
   logic rsp_free;
   logic cur_ok;
   logic prev_ok;
   logic walk_more;
   logic found;

   salls_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   salls_store u_store (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .rd_addr    (rd_addr),
      .key_we     (key_we),
      .key_waddr  (free_head_ff[SLOT_W-1:0]),
      .key_wdata  (key_ff),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .key_rd     (key_rd),
      .link_rd    (link_rd)
   );

   // handshakes
   assign req_tready = (ctl.act == ACT_ACCEPT);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // walk conditions on the element read last cycle
   assign cur_ok    = (cur_ff < NIL) && (steps_ff < STEP_W'(SLOTS));
   assign prev_ok   = (prev_ff < NIL);
   assign walk_more = cur_ok && (key_rd < key_ff);
   assign found     = cur_ok && (key_rd == key_ff);

   always_comb begin
      flags.req_fire  = req_fire;
      flags.cmd       = req_fire ? cmd_type'(req_tdata[1:0]) : cmd_ff;
      flags.full      = !(free_head_ff < NIL);
      flags.walk_more = walk_more;
      flags.found     = found;
      flags.rsp_free  = rsp_free;
   end

   // memory read address
   always_comb begin
      case (ctl.act)
         ACT_WALK_INIT: rd_addr = list_head_ff[SLOT_W-1:0];
         ACT_WALK:      rd_addr = link_rd[SLOT_W-1:0];
         ACT_INS_RD:    rd_addr = free_head_ff[SLOT_W-1:0];
         default:       rd_addr = cur_ff[SLOT_W-1:0];
      endcase
   end

   // memory writes
   always_comb begin
      key_we     = 1'b0;
      link_we    = 1'b0;
      link_waddr = prev_ff[SLOT_W-1:0];
      link_wdata = curlink_ff;
      clear      = (ctl.act == ACT_CLEAR);
      case (ctl.act)
         ACT_INS_A: begin
            key_we     = 1'b1;
            link_we    = 1'b1;
            link_waddr = free_head_ff[SLOT_W-1:0];
            link_wdata = prev_ok ? cur_ff : list_head_ff;
         end
         ACT_INS_B: begin
            link_we    = prev_ok;
            link_wdata = LINK_W'(res_slot_ff);
         end
         ACT_DEL_A: begin
            link_we    = prev_ok;
         end
         ACT_DEL_B: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[SLOT_W-1:0];
            link_wdata = free_head_ff;
         end
         default: begin
            key_we     = 1'b0;
         end
      endcase
   end

   // datapath next state
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      curlink_in    = curlink_ff;
      steps_in      = steps_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (ctl.act)
         ACT_ACCEPT: begin
            if (req_fire) begin
               cmd_in        = cmd_type'(req_tdata[1:0]);
               key_in        = $signed(req_tdata[33:2]);
               res_status_in = ST_OK;
               res_slot_in   = '0;
            end
         end
         ACT_WALK_INIT: begin
            prev_in  = NIL;
            cur_in   = list_head_ff;
            steps_in = '0;
         end
         ACT_WALK: begin
            curlink_in = link_rd;
            if (walk_more) begin
               prev_in  = cur_ff;
               cur_in   = link_rd;
               steps_in = steps_ff + STEP_W'(1);
            end
         end
         ACT_INS_A: begin
            free_head_in = link_rd;
            res_slot_in  = free_head_ff[SLOT_W-1:0];
            count_in     = count_ff + COUNT_W'(1);
            if (!prev_ok) begin
               list_head_in = free_head_ff;
            end
         end
         ACT_DEL_A: begin
            if (!prev_ok) begin
               list_head_in = curlink_ff;
            end
         end
         ACT_DEL_B: begin
            free_head_in = cur_ff;
            res_slot_in  = cur_ff[SLOT_W-1:0];
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         ACT_FOUND: begin
            res_slot_in = cur_ff[SLOT_W-1:0];
         end
         ACT_SET_DUP: begin
            res_status_in = ST_DUP;
         end
         ACT_SET_NF: begin
            res_status_in = ST_NOT_FOUND;
         end
         ACT_SET_FULL: begin
            res_status_in = ST_FULL;
         end
         ACT_CLEAR: begin
            list_head_in = NIL;
            free_head_in = '0;
            count_in     = '0;
         end
         ACT_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, count_ff, SLOT_OUT_W'(res_slot_ff), res_status_ff};
            end
         end
         default: begin
            cmd_in = cmd_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         list_head_ff <= NIL;
         free_head_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      curlink_ff    <= curlink_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
